@@ hw/rtl/ahb_pkg.sv @@
// Shared types and constants for the axis homing with backoff block.
package ahb_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned InDataW  = 40;  // 1 + 32 packed, padded to bytes
  localparam int unsigned OutDataW = 72;  // 1 + 1 + 2 + 1 + 32 + 32, padded

  localparam logic [CountW-1:0] BackoffReset  = 16'd100;
  localparam logic [CountW-1:0] DebounceReset = 16'd50;
  localparam logic [PosW-1:0]   MaxPosReset   = '1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT_KIND    = 2'd0,
    CFG_BACKOFF_STEPS = 2'd1,
    CFG_DEBOUNCE_MS   = 2'd2
  } cfg_idx_t;

  // Debouncer state
  typedef enum logic [1:0] {
    PRESS_OPEN = 2'd0,
    PRESS_WAIT = 2'd1,
    PRESS_HELD = 2'd2
  } press_t;

  // Reported homing phase
  typedef enum logic [1:0] {
    PHASE_SEEK    = 2'd0,
    PHASE_BACKOFF = 2'd1,
    PHASE_SET     = 2'd2
  } phase_t;

  typedef struct packed {
    logic              restart;
    logic              level;
    logic [TimeW-1:0]  now_ms;
  } poll_t;

  typedef struct packed {
    logic              limit_kind;
    logic [CountW-1:0] backoff_steps;
    logic [CountW-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic              step_pulse;
    logic              step_dir;
    phase_t            phase;
    logic              switch_active;
    logic [PosW-1:0]   position;
    logic [PosW-1:0]   axis_max;
  } result_t;

endpackage

@@ hw/rtl/ahb_debounce.sv @@
// Latching debouncer for the active-low limit switch.
module ahb_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  ahb_pkg::poll_t             poll,
  input  logic [ahb_pkg::CountW-1:0] debounce_ms,
  output logic                       status_next
);

  ahb_pkg::press_t             press;
  ahb_pkg::press_t             press_next;
  logic [ahb_pkg::TimeW-1:0]   press_start;
  logic [ahb_pkg::TimeW-1:0]   press_start_next;
  logic                        status;
  logic [ahb_pkg::TimeW-1:0]   elapsed;
  logic                        held_long;

  assign elapsed   = poll.now_ms - press_start;
  assign held_long = elapsed > {{(ahb_pkg::TimeW - ahb_pkg::CountW){1'b0}}, debounce_ms};

  // Next state
  always_comb begin
    press_next       = press;
    press_start_next = press_start;
    if (!poll.restart) begin
      if (!poll.level) begin
        case (press)
          ahb_pkg::PRESS_OPEN: begin
            press_next       = ahb_pkg::PRESS_WAIT;
            press_start_next = poll.now_ms;
          end
          ahb_pkg::PRESS_WAIT: begin
            if (held_long) press_next = ahb_pkg::PRESS_HELD;
          end
          default: begin
            press_next = press;
          end
        endcase
      end else begin
        press_next = ahb_pkg::PRESS_OPEN;
      end
    end
  end

  // Debounced status
  always_comb begin
    status_next = status;
    if (!poll.restart) begin
      if (poll.level) begin
        status_next = 1'b0;
      end else if (press == ahb_pkg::PRESS_WAIT && held_long) begin
        status_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press       <= ahb_pkg::PRESS_OPEN;
      press_start <= '0;
      status      <= 1'b0;
    end else if (en) begin
      press       <= press_next;
      press_start <= press_start_next;
      status      <= status_next;
    end
  end

endmodule

@@ hw/rtl/ahb_sequencer.sv @@
// Seek, backoff and limit capture for one axis.
module ahb_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             restart,
  input  logic             switch_on,
  input  ahb_pkg::cfg_t    cfg,
  output ahb_pkg::result_t result
);

  logic                       found;
  logic                       found_next;
  logic                       done;
  logic                       done_next;
  logic [ahb_pkg::CountW-1:0] backoff_left;
  logic [ahb_pkg::CountW-1:0] backoff_left_next;
  logic [ahb_pkg::PosW-1:0]   position;
  logic [ahb_pkg::PosW-1:0]   position_next;
  logic [ahb_pkg::PosW-1:0]   max_pos;
  logic [ahb_pkg::PosW-1:0]   max_pos_next;
  logic                       pulse;
  logic                       dir;
  logic [ahb_pkg::PosW-1:0]   stepped;

  assign stepped = dir ? position + ahb_pkg::PosW'(1) : position - ahb_pkg::PosW'(1);

  always_comb begin
    found_next        = found;
    done_next         = done;
    backoff_left_next = backoff_left;
    position_next     = position;
    max_pos_next      = max_pos;
    pulse             = 1'b0;
    dir               = 1'b0;
    if (restart) begin
      found_next = 1'b0;
      done_next  = 1'b0;
    end else if (!switch_on && !found) begin
      // seek toward the switch
      dir           = cfg.limit_kind;
      pulse         = 1'b1;
      position_next = stepped;
    end else if (switch_on && !found) begin
      // trip: load backoff, no step this poll
      found_next        = 1'b1;
      backoff_left_next = cfg.backoff_steps;
    end else if (found && !done) begin
      dir           = ~cfg.limit_kind;
      pulse         = 1'b1;
      position_next = stepped;
      if (backoff_left <= ahb_pkg::CountW'(1)) begin
        backoff_left_next = '0;
        done_next         = 1'b1;
        if (cfg.limit_kind) max_pos_next  = stepped;
        else                position_next = '0;
      end else begin
        backoff_left_next = backoff_left - ahb_pkg::CountW'(1);
      end
    end
  end

  always_comb begin
    result.step_pulse    = pulse;
    result.step_dir      = dir;
    result.switch_active = switch_on;
    result.position      = position_next;
    result.axis_max      = max_pos_next;
    if (done_next)       result.phase = ahb_pkg::PHASE_SET;
    else if (found_next) result.phase = ahb_pkg::PHASE_BACKOFF;
    else                 result.phase = ahb_pkg::PHASE_SEEK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found        <= 1'b0;
      done         <= 1'b0;
      backoff_left <= '0;
      position     <= '0;
      max_pos      <= ahb_pkg::MaxPosReset;
    end else if (en) begin
      found        <= found_next;
      done         <= done_next;
      backoff_left <= backoff_left_next;
      position     <= position_next;
      max_pos      <= max_pos_next;
    end
  end

endmodule

@@ hw/rtl/axis_homing_with_backoff.sv @@
// Path: a poll word is taken into the poll register, then into the result register on m_tvalid.
// Throughput: one poll word per cycle while m_tready is high; the poll and result
//   registers run as a two-deep pipe, so the next word is taken while a result waits.
// Reset: synchronous, active high; clears both pipe stages, the debouncer, the
//   homing flags and position, sets axis_max to all ones and loads config defaults.
// Top level: homes one stepper axis against a limit switch, then backs off.
module axis_homing_with_backoff (
  input  logic                         clk,
  input  logic                         rst,
  // poll words
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ahb_pkg::InDataW-1:0]  s_tdata,   // switch_level, now_ms[31:0], zero pad
  input  logic                         s_tuser,   // mode (1 = restart homing)
  // result words
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ahb_pkg::OutDataW-1:0] m_tdata,   // step_pulse, step_dir, phase[1:0],
                                                  // switch_active, position[31:0],
                                                  // axis_max[31:0], zero pad
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ahb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ahb_pkg::CfgDataW-1:0] cfg_data
);

  ahb_pkg::cfg_t    cfg;
  ahb_pkg::poll_t   poll;
  logic             poll_valid;
  logic             advance;
  logic             switch_on;
  ahb_pkg::result_t result;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_kind    <= 1'b0;
      cfg.backoff_steps <= ahb_pkg::BackoffReset;
      cfg.debounce_ms   <= ahb_pkg::DebounceReset;
    end else if (cfg_valid) begin
      case (ahb_pkg::cfg_idx_t'(cfg_index))
        ahb_pkg::CFG_LIMIT_KIND:    cfg.limit_kind    <= cfg_data[0];
        ahb_pkg::CFG_BACKOFF_STEPS: cfg.backoff_steps <= cfg_data;
        ahb_pkg::CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Poll register: advance into the result register when that slot is free
  // or being drained this cycle.
  assign advance  = poll_valid && (!m_tvalid || m_tready);
  assign s_tready = !poll_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (s_tready) begin
      poll_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      poll.restart <= s_tuser;
      poll.level   <= s_tdata[0];
      poll.now_ms  <= s_tdata[ahb_pkg::TimeW:1];
    end
  end

  // Debounce, then sequence; state commits only as the word moves on.
  ahb_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .poll        (poll),
    .debounce_ms (cfg.debounce_ms),
    .status_next (switch_on)
  );

  ahb_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .restart   (poll.restart),
    .switch_on (switch_on),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'b000, result.axis_max, result.position, result.switch_active,
                  result.phase, result.step_dir, result.step_pulse};
    end
  end

endmodule
